// ===== design/kth_smallest_quickselect_defines.svh =====
// Assertion macros shared by the quickselect RTL.
// Depends on nothing; users must have signals named clock and reset in scope.
`ifndef KTH_SMALLEST_QUICKSELECT_DEFINES_SVH
`define KTH_SMALLEST_QUICKSELECT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define KSQ_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define KSQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/ksq_pkg.sv =====
// Shared types and defaults of the quickselect block.
// Used by the controller, the datapath and the top level; depends on nothing.
package ksq_pkg;

   localparam int unsigned MAX_ELEMENTS_DEF = 64;
   localparam int unsigned VALUE_BITS_DEF   = 32;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_CHECK,
      ST_PIV_CAP,
      ST_SCAN,
      ST_SCAN_CMP,
      ST_SWAP_WS,
      ST_SWAP_WB,
      ST_FIN_WH,
      ST_FIN_WB,
      ST_LAST_CAP,
      ST_EMIT
   } state_type;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_LOAD,
      OP_LOAD_LAST,
      OP_CHECK,
      OP_PIV_CAP,
      OP_SCAN_RD,
      OP_SCAN_SKIP,
      OP_SCAN_KEEP,
      OP_SWAP_RDB,
      OP_SWAP_WS,
      OP_SWAP_WB,
      OP_FIN_RDB,
      OP_FIN_WH,
      OP_FIN_WB,
      OP_LAST_CAP,
      OP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic rank_bad;    // rank of the incoming last request is zero or above the count
      logic range_open;  // current range holds more than one entry
      logic scan_done;   // scan index has reached the pivot slot
      logic not_above;   // entry just read is not above the pivot
      logic same_slot;   // boundary and scan index coincide
      logic rank_hit;    // pivot landed exactly on the wanted rank
      logic out_free;    // result register can take a new result
   } dp_status_type;

endpackage

// ===== design/ksq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module ksq_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64,
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/ksq_ctrl.sv =====
// Sequencer of the quickselect block: loading, Lomuto partition passes, result.
// Depends on ksq_pkg; drives the datapath only through dp_cmd_type.
module ksq_ctrl import ksq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_tlast,
   output logic          req_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_tvalid && req_tlast) begin
               state_in = status.rank_bad ? ST_EMIT : ST_CHECK;
            end
         end
         ST_CHECK:    state_in = status.range_open ? ST_PIV_CAP : ST_LAST_CAP;
         ST_PIV_CAP:  state_in = ST_SCAN;
         ST_SCAN:     state_in = status.scan_done ? ST_FIN_WH : ST_SCAN_CMP;
         ST_SCAN_CMP: begin
            if (status.not_above && !status.same_slot) begin
               state_in = ST_SWAP_WS;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SWAP_WS:  state_in = ST_SWAP_WB;
         ST_SWAP_WB:  state_in = ST_SCAN;
         ST_FIN_WH:   state_in = ST_FIN_WB;
         ST_FIN_WB:   state_in = status.rank_hit ? ST_EMIT : ST_CHECK;
         ST_LAST_CAP: state_in = ST_EMIT;
         ST_EMIT:     state_in = status.out_free ? ST_LOAD : ST_EMIT;
         default:     state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd.op     = OP_IDLE;
      case (state_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op = req_tlast ? OP_LOAD_LAST : OP_LOAD;
            end
         end
         ST_CHECK:    cmd.op = OP_CHECK;
         ST_PIV_CAP:  cmd.op = OP_PIV_CAP;
         ST_SCAN:     cmd.op = status.scan_done ? OP_FIN_RDB : OP_SCAN_RD;
         ST_SCAN_CMP: begin
            if (!status.not_above) begin
               cmd.op = OP_SCAN_SKIP;
            end else if (status.same_slot) begin
               cmd.op = OP_SCAN_KEEP;
            end else begin
               cmd.op = OP_SWAP_RDB;
            end
         end
         ST_SWAP_WS:  cmd.op = OP_SWAP_WS;
         ST_SWAP_WB:  cmd.op = OP_SWAP_WB;
         ST_FIN_WH:   cmd.op = OP_FIN_WH;
         ST_FIN_WB:   cmd.op = OP_FIN_WB;
         ST_LAST_CAP: cmd.op = OP_LAST_CAP;
         ST_EMIT:     cmd.op = OP_EMIT;
         default:     cmd.op = OP_IDLE;
      endcase
   end

endmodule

// ===== design/ksq_dpath.sv =====
// Datapath of the quickselect block: element store, range and scan registers,
// pivot compare and the result register. Depends on ksq_pkg and ksq_ram.
`include "kth_smallest_quickselect_defines.svh"

module ksq_dpath import ksq_pkg::*; #(
   parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF,
   parameter int unsigned VALUE_BITS   = VALUE_BITS_DEF,
   localparam int unsigned IDX_BITS = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1,
   localparam int unsigned CNT_BITS = $clog2(MAX_ELEMENTS + 1),
   localparam int unsigned REQ_W    = ((VALUE_BITS + CNT_BITS + 7) / 8) * 8,
   localparam int unsigned RSP_W    = ((VALUE_BITS + 7) / 8) * 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [REQ_W-1:0] req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,
   output logic          rsp_tuser,
   input  dp_cmd_type    cmd,
   output dp_status_type status
);

   logic [VALUE_BITS-1:0] sample;
   logic [CNT_BITS-1:0]   rank_in;

   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [IDX_BITS-1:0]   low_ff, low_in;
   logic [IDX_BITS-1:0]   high_ff, high_in;
   logic [IDX_BITS-1:0]   scan_ff, scan_in;
   logic [IDX_BITS-1:0]   bound_ff, bound_in;
   logic [CNT_BITS-1:0]   rank_left_ff, rank_left_in;
   logic                  err_ff, err_in;
   logic [VALUE_BITS-1:0] pivot_ff, pivot_in;
   logic [VALUE_BITS-1:0] tmp_ff, tmp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic                  rsp_err_ff, rsp_err_in;

   logic                  count_full;
   logic [CNT_BITS-1:0]   count_next;
   logic [CNT_BITS-1:0]   part_rank;
   logic [CNT_BITS-1:0]   range_span;
   logic                  rank_below;

   logic                  wr_en;
   logic [IDX_BITS-1:0]   wr_addr;
   logic [VALUE_BITS-1:0] wr_data;
   logic                  rd_en;
   logic [IDX_BITS-1:0]   rd_addr;
   logic [VALUE_BITS-1:0] rd_data;

   logic                  chk_scan_step;
   logic                  chk_scan_order;
   logic                  chk_piv_step;
   logic                  chk_rank_ok;
   logic                  chk_emit_step;

   assign sample  = req_tdata[VALUE_BITS-1:0];
   assign rank_in = req_tdata[VALUE_BITS+CNT_BITS-1:VALUE_BITS];

   assign count_full = (count_ff == CNT_BITS'(MAX_ELEMENTS));
   assign count_next = count_full ? count_ff : count_ff + 1'b1;
   assign part_rank  = CNT_BITS'(bound_ff) - CNT_BITS'(low_ff) + 1'b1;
   assign range_span = CNT_BITS'(high_ff) - CNT_BITS'(low_ff) + 1'b1;
   assign rank_below = (rank_left_ff < part_rank);

   assign status.rank_bad   = (rank_in == '0) || (rank_in > count_next);
   assign status.range_open = (low_ff < high_ff);
   assign status.scan_done  = (scan_ff == high_ff);
   assign status.not_above  = ($signed(rd_data) <= $signed(pivot_ff));
   assign status.same_slot  = (bound_ff == scan_ff);
   assign status.rank_hit   = (part_rank == rank_left_ff);
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

   ksq_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (MAX_ELEMENTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Store port selection. Read data stays put while no read is issued, so the
   // swap steps can write back what the previous read returned.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = bound_ff;
      wr_data = pivot_ff;
      rd_en   = 1'b0;
      rd_addr = scan_ff;
      case (cmd.op)
         OP_LOAD, OP_LOAD_LAST: begin
            wr_en   = !count_full;
            wr_addr = count_ff[IDX_BITS-1:0];
            wr_data = sample;
         end
         OP_CHECK: begin
            rd_en   = 1'b1;
            rd_addr = status.range_open ? high_ff : low_ff;
         end
         OP_SCAN_RD: begin
            rd_en   = 1'b1;
            rd_addr = scan_ff;
         end
         OP_SWAP_RDB, OP_FIN_RDB: begin
            rd_en   = 1'b1;
            rd_addr = bound_ff;
         end
         OP_SWAP_WS: begin
            wr_en   = 1'b1;
            wr_addr = scan_ff;
            wr_data = rd_data;
         end
         OP_SWAP_WB: begin
            wr_en   = 1'b1;
            wr_addr = bound_ff;
            wr_data = tmp_ff;
         end
         OP_FIN_WH: begin
            wr_en   = 1'b1;
            wr_addr = high_ff;
            wr_data = rd_data;
         end
         OP_FIN_WB: begin
            wr_en   = 1'b1;
            wr_addr = bound_ff;
            wr_data = pivot_ff;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      count_in     = count_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      scan_in      = scan_ff;
      bound_in     = bound_ff;
      rank_left_in = rank_left_ff;
      err_in       = err_ff;
      pivot_in     = pivot_ff;
      tmp_in       = tmp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      rsp_err_in   = rsp_err_ff;
      case (cmd.op)
         OP_LOAD: begin
            count_in = count_next;
         end
         OP_LOAD_LAST: begin
            count_in     = '0;
            err_in       = status.rank_bad;
            low_in       = '0;
            high_in      = IDX_BITS'(count_next - 1'b1);
            rank_left_in = rank_in;
         end
         OP_PIV_CAP: begin
            pivot_in = rd_data;
            bound_in = low_ff;
            scan_in  = low_ff;
         end
         OP_SCAN_SKIP: begin
            scan_in = scan_ff + 1'b1;
         end
         OP_SCAN_KEEP, OP_SWAP_WB: begin
            scan_in  = scan_ff + 1'b1;
            bound_in = bound_ff + 1'b1;
         end
         OP_SWAP_RDB: begin
            tmp_in = rd_data;
         end
         OP_FIN_WB: begin
            if (!status.rank_hit) begin
               if (rank_below) begin
                  high_in = bound_ff - 1'b1;
               end else begin
                  low_in       = bound_ff + 1'b1;
                  rank_left_in = rank_left_ff - part_rank;
               end
            end
         end
         OP_LAST_CAP: begin
            pivot_in = rd_data;
         end
         OP_EMIT: begin
            if (status.out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = err_ff ? '0 : pivot_ff;
               rsp_err_in   = err_ff;
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         low_ff       <= '0;
         high_ff      <= '0;
         scan_ff      <= '0;
         bound_ff     <= '0;
         rank_left_ff <= '0;
         err_ff       <= 1'b0;
         pivot_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         scan_ff      <= scan_in;
         bound_ff     <= bound_in;
         rank_left_ff <= rank_left_in;
         err_ff       <= err_in;
         pivot_ff     <= pivot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tmp_ff       <= tmp_in;
      rsp_value_ff <= rsp_value_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_value_ff);
   assign rsp_tuser  = rsp_err_ff;

   assign chk_scan_step  = (cmd.op == OP_SCAN_RD) || (cmd.op == OP_SWAP_RDB);
   assign chk_scan_order = (bound_ff <= scan_ff) && (scan_ff < high_ff);
   assign chk_piv_step   = (cmd.op == OP_PIV_CAP);
   assign chk_rank_ok    = (rank_left_ff != '0) && (rank_left_ff <= range_span);
   assign chk_emit_step  = (cmd.op == OP_EMIT) && status.out_free;

   `KSQ_ASSERT_SAME(a_scan_order, chk_scan_step, chk_scan_order, "scan index outside the range")
   `KSQ_ASSERT_SAME(a_rank_in_range, chk_piv_step, chk_rank_ok, "wanted rank left the range")
   `KSQ_ASSERT_NEXT(a_emit_loads, chk_emit_step, rsp_valid_ff, "result not presented after emit")

endmodule

// ===== design/kth_smallest_quickselect.sv =====
// Top level of the k-th smallest selector: controller plus datapath.
// Depends on ksq_pkg, ksq_ctrl, ksq_dpath (and through it ksq_ram).
//
// The block collects a set of signed values, one per request, into an on-chip
// store of MAX_ELEMENTS entries; values beyond that count are dropped. The
// request flagged with tlast also carries the wanted 1-based rank k, and once
// it is taken the block runs quickselect in place: a Lomuto partition around
// the last entry of the current range, then narrowing to the side that holds
// rank k. Exactly one result follows each last request: the k-th smallest
// value with rank_error low, or zero with rank_error high when k is zero or
// above the number of held values. Loading takes one request per cycle. The
// selection is paced by the single read port of the store. Each partition
// pass reads the last entry of the range as its pivot, then reads each entry
// and compares it with the pivot; an entry that is not above the pivot and
// not at the boundary is swapped with the boundary entry by a read and two
// writes. Finally the boundary entry moves to the pivot slot and the pivot
// to the boundary. A set already in order is slow, as each pass then splits
// off only its pivot. Requests are refused while a selection runs. The result
// sits in an output register, so loading of the next set starts as soon as
// the result has been placed there, even if the receiver has not yet taken it.
module kth_smallest_quickselect import ksq_pkg::*; #(
   parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF,
   parameter int unsigned VALUE_BITS   = VALUE_BITS_DEF,
   localparam int unsigned CNT_BITS = $clog2(MAX_ELEMENTS + 1),
   localparam int unsigned REQ_W    = ((VALUE_BITS + CNT_BITS + 7) / 8) * 8,
   localparam int unsigned RSP_W    = ((VALUE_BITS + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   // Request channel.
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,  // sample_value, wanted_rank, zero fill
   input  logic             req_tlast,  // is_last
   // Result channel.
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,  // selected_value, zero fill
   output logic             rsp_tuser   // rank_error
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // The controller walks the load, partition and result steps; it sees only
   // the handshake bits and the datapath's status flags.
   ksq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds the store, the range and scan indexes, the pivot and
   // the result register, and carries out one command per cycle.
   ksq_dpath #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .VALUE_BITS   (VALUE_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

// ===== test/kth_smallest_quickselect_tb.sv =====
// Self-checking testbench for kth_smallest_quickselect: streams signed value sets into the
// block and compares each selected value and rank_error flag with an in-bench predictor.
// Depends on ksq_pkg and the kth_smallest_quickselect RTL only.
`timescale 1ns / 100ps

module kth_smallest_quickselect_tb;
   import ksq_pkg::MAX_ELEMENTS_DEF;
   import ksq_pkg::VALUE_BITS_DEF;

   localparam int unsigned DEPTH    = MAX_ELEMENTS_DEF;
   localparam int unsigned VBITS    = VALUE_BITS_DEF;
   localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);
   localparam int unsigned REQ_W    = ((VBITS + CNT_BITS + 7) / 8) * 8;
   localparam int unsigned RSP_W    = ((VBITS + 7) / 8) * 8;
   localparam int unsigned MAX_RANK = (1 << CNT_BITS) - 1;

   // About 1750 requests in total; the directed table supplies the first few.
   localparam int unsigned RANDOM_ITEMS = 1730;
   // This limit only trips on a hang, not on a slow correct run with large sorted sets.
   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int unsigned SETTLE_CYCLES = 200;
   localparam int unsigned REPORT_LIMIT = 10;

   // One row of the directed table. Rows with has_fixed carry their expected result;
   // the rest are checked against the predictor.
   typedef struct packed {
      logic [31:0] value;
      logic        last;
      logic [6:0]  rank;
      logic        has_fixed;
      logic [31:0] fixed_value;
      logic        fixed_err;
   } step_row_type;

   typedef struct packed {
      logic [VBITS-1:0] value;
      logic             err;
   } pick_result_type;

   typedef enum {
      FILL_RANDOM,
      FILL_NARROW,
      FILL_RISING,
      FILL_FALLING,
      FILL_EDGES
   } fill_kind_type;

   localparam int unsigned DIRECTED_COUNT = 19;
   localparam step_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // A set of one: the single value is both smallest and largest.
      '{32'h7FFF_FFFF, 1'b1, 7'd1,   1'b1, 32'h7FFF_FFFF, 1'b0},
      '{32'h8000_0000, 1'b1, 7'd1,   1'b1, 32'h8000_0000, 1'b0},
      // Rank zero is out of range.
      '{32'h0000_0005, 1'b1, 7'd0,   1'b1, 32'h0000_0000, 1'b1},
      // Rank above the count of a two-value set; the rank on the first value is ignored.
      '{32'h0000_0003, 1'b0, 7'd127, 1'b0, 32'h0000_0000, 1'b0},
      '{32'hFFFF_FFFF, 1'b1, 7'd3,   1'b1, 32'h0000_0000, 1'b1},
      // Both extremes of the value range in one set.
      '{32'h8000_0000, 1'b0, 7'd0,   1'b0, 32'h0000_0000, 1'b0},
      '{32'h7FFF_FFFF, 1'b0, 7'd64,  1'b0, 32'h0000_0000, 1'b0},
      '{32'h0000_0000, 1'b1, 7'd2,   1'b0, 32'h0000_0000, 1'b0},
      // Equal values all go left of the pivot.
      '{32'h0000_0007, 1'b0, 7'd1,   1'b0, 32'h0000_0000, 1'b0},
      '{32'h0000_0007, 1'b0, 7'd1,   1'b0, 32'h0000_0000, 1'b0},
      '{32'h0000_0007, 1'b1, 7'd2,   1'b0, 32'h0000_0000, 1'b0},
      // Values already in order, largest rank.
      '{32'h0000_0001, 1'b0, 7'd0,   1'b0, 32'h0000_0000, 1'b0},
      '{32'h0000_0002, 1'b0, 7'd0,   1'b0, 32'h0000_0000, 1'b0},
      '{32'h0000_0003, 1'b0, 7'd0,   1'b0, 32'h0000_0000, 1'b0},
      '{32'h0000_0004, 1'b1, 7'd4,   1'b0, 32'h0000_0000, 1'b0},
      // Values in reverse order with a negative one, smallest rank.
      '{32'h0000_0009, 1'b0, 7'd0,   1'b0, 32'h0000_0000, 1'b0},
      '{32'h0000_0005, 1'b0, 7'd0,   1'b0, 32'h0000_0000, 1'b0},
      '{32'hFFFF_FFFC, 1'b1, 7'd1,   1'b0, 32'h0000_0000, 1'b0},
      // Highest rank the field can carry, far above a count of one.
      '{32'h1234_5678, 1'b1, 7'd127, 1'b1, 32'h0000_0000, 1'b1}
   };

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;   // sample_value, wanted_rank, zero fill
   logic             req_tlast = 1'b0; // is_last
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;        // selected_value, zero fill
   logic             rsp_tuser;        // rank_error

   kth_smallest_quickselect dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // Predictor state: the values held for the current set, in arrival order.
   logic signed [VBITS-1:0] held_values [DEPTH];
   int unsigned             held_count = 0;

   // Results the block still owes, oldest first.
   pick_result_type awaited_picks [$];

   int unsigned fail_count     = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;

   // While calm is set neither side inserts idle cycles.
   bit calm = 1'b0;

   // Quickselect on a copy of the held values: Lomuto partition around the last entry of
   // the range, then narrow to the side that holds the wanted rank.
   function automatic logic [VBITS-1:0] select_kth(input int unsigned count,
                                                   input int unsigned wanted);
      logic signed [VBITS-1:0] work [DEPTH];
      logic signed [VBITS-1:0] pivot;
      logic signed [VBITS-1:0] spare;
      int lo;
      int hi;
      int bound;
      int rank;
      int rank_left;
      work = held_values;
      lo = 0;
      hi = int'(count) - 1;
      rank_left = int'(wanted);
      while (lo < hi) begin
         pivot = work[hi];
         bound = lo;
         for (int i = lo; i < hi; i++) begin
            if (work[i] <= pivot) begin
               spare = work[bound];
               work[bound] = work[i];
               work[i] = spare;
               bound++;
            end
         end
         spare = work[bound];
         work[bound] = work[hi];
         work[hi] = spare;
         rank = bound - lo + 1;
         if (rank == rank_left) return work[bound];
         if (rank_left < rank) begin
            hi = bound - 1;
         end else begin
            lo = bound + 1;
            rank_left -= rank;
         end
      end
      return work[lo];
   endfunction

   // Takes one accepted request into the predictor. A last request yields a result and
   // starts a new set; values beyond the store depth are dropped.
   function automatic bit absorb_sample(input logic [VBITS-1:0] value, input bit last,
                                        input logic [6:0] rank,
                                        output pick_result_type pick);
      pick = '0;
      if (held_count < DEPTH) begin
         held_values[held_count] = value;
         held_count++;
      end
      if (!last) return 1'b0;
      if (rank == 0 || rank > held_count) begin
         pick.err = 1'b1;
      end else begin
         pick.value = select_kth(held_count, rank);
      end
      held_count = 0;
      return 1'b1;
   endfunction

   // Drives one request from a falling edge, waits for the handshake, records the
   // expected result and returns at the next falling edge.
   task automatic send_request(input logic [31:0] value, input bit last,
                               input logic [6:0] rank, input bit has_fixed,
                               input logic [31:0] fixed_value, input bit fixed_err);
      pick_result_type pick;
      bit              produced;
      while (!calm && $urandom_range(0, 99) < 15) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_W - VBITS - CNT_BITS){1'b0}}, rank, value};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      produced = absorb_sample(value, last, rank, pick);
      if (produced) begin
         if (has_fixed) begin
            pick.value = fixed_value;
            pick.err   = fixed_err;
         end
         awaited_picks.push_back(pick);
      end
      @(negedge clock);
   endtask

   // Holds the request side idle until every owed result has come back.
   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (awaited_picks.size() != 0) @(negedge clock);
   endtask

   function automatic logic [31:0] make_value(input fill_kind_type kind,
                                              input int unsigned idx,
                                              input logic [31:0] base,
                                              input logic [31:0] stride);
      logic [31:0] edges [5];
      edges = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001};
      case (kind)
         FILL_NARROW:  return $urandom_range(0, 8) - 4;
         FILL_RISING:  return base + idx * stride;
         FILL_FALLING: return base - idx * stride;
         FILL_EDGES:   return edges[$urandom_range(0, 4)];
         default:      return $urandom;
      endcase
   endfunction

   // The receiver stalls about 15 percent of the time, except during the calm stretch.
   always @(negedge clock) begin
      rsp_tready <= calm || ($urandom_range(0, 99) >= 15);
   end

   // Result checker: every accepted result is matched against the oldest expectation.
   always @(posedge clock) begin
      pick_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_picks.size() == 0) begin
            fail_count++;
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected result: value %h rank_error %b",
                        rsp_tdata[VBITS-1:0], rsp_tuser);
         end else begin
            want = awaited_picks.pop_front();
            if (rsp_tdata !== RSP_W'(want.value) || rsp_tuser !== want.err) begin
               fail_count++;
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("result mismatch: expected value %h rank_error %b, got %h %b",
                           want.value, want.err, rsp_tdata, rsp_tuser);
            end
         end
      end
   end

   // Watchdog: a hang in the block ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("kth_smallest_quickselect_tb: done, errors");
         $finish;
      end
   end

   int unsigned   sent_items;
   int unsigned   set_index;
   int unsigned   set_size;
   int unsigned   held;
   int unsigned   roll;
   logic [6:0]    set_rank;
   logic [31:0]   fill_base;
   logic [31:0]   fill_stride;
   fill_kind_type kind;

   initial begin
      // Reset starts high and is released on a falling edge.
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: extremes, rank errors, equal values, ordered sets.
      for (int r = 0; r < DIRECTED_COUNT; r++) begin
         send_request(DIRECTED_ROWS[r].value, DIRECTED_ROWS[r].last, DIRECTED_ROWS[r].rank,
                      DIRECTED_ROWS[r].has_fixed, DIRECTED_ROWS[r].fixed_value,
                      DIRECTED_ROWS[r].fixed_err);
      end

      // Let every directed result come home before random traffic starts.
      hold_until_drained();

      // Random part: whole sets with random content, mostly small, a few filling or
      // overflowing the store, and some in order to drive the slow partition path.
      sent_items = 0;
      set_index  = 0;
      while (sent_items < RANDOM_ITEMS) begin
         calm = (set_index >= 40 && set_index < 60);
         roll = $urandom_range(0, 99);
         if (set_index == 5) begin
            set_size = 70;
         end else if (set_index == 30) begin
            set_size = DEPTH;
         end else if (set_index % 25 == 5) begin
            set_size = $urandom_range(DEPTH - 4, DEPTH + 8);
         end else if (roll < 70) begin
            set_size = $urandom_range(1, 12);
         end else if (roll < 92) begin
            set_size = $urandom_range(13, 40);
         end else begin
            set_size = $urandom_range(41, DEPTH + 6);
         end
         held = (set_size > DEPTH) ? DEPTH : set_size;

         // Mostly a rank that exists; otherwise zero or a rank above the held count.
         roll = $urandom_range(0, 99);
         if (set_index == 5) begin
            set_rank = 7'(DEPTH);
         end else if (set_index == 30) begin
            set_rank = 7'd1;
         end else if (roll < 85) begin
            set_rank = 7'($urandom_range(1, held));
         end else if (roll < 92 || held >= MAX_RANK) begin
            set_rank = 7'd0;
         end else begin
            set_rank = 7'($urandom_range(held + 1, MAX_RANK));
         end

         roll = $urandom_range(0, 99);
         if (set_index == 30) kind = FILL_RISING;
         else if (roll < 50) kind = FILL_RANDOM;
         else if (roll < 65) kind = FILL_NARROW;
         else if (roll < 77) kind = FILL_RISING;
         else if (roll < 89) kind = FILL_FALLING;
         else kind = FILL_EDGES;
         fill_base   = (set_index == 30) ? 32'hFFFF_FF00 : $urandom;
         fill_stride = $urandom_range(1, 4096);

         // The rank field of the non-last requests is random and must be ignored.
         for (int i = 0; i < set_size; i++) begin
            send_request(make_value(kind, i, fill_base, fill_stride), i == set_size - 1,
                         (i == set_size - 1) ? set_rank : 7'($urandom_range(0, MAX_RANK)),
                         1'b0, 32'h0, 1'b0);
         end
         sent_items += set_size;
         set_index++;
         if (set_index % 30 == 0) hold_until_drained();
      end
      calm = 1'b0;

      // Wrap up: wait for the last results, then watch for anything spurious.
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (awaited_picks.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("kth_smallest_quickselect_tb: done, clean");
      end else begin
         $display("kth_smallest_quickselect_tb: done, errors");
      end
      $finish;
   end

endmodule
